[design/random_vertical_band_displacement_macros.svh]
// Assertion macros shared by the checker of the band displacement block.
`ifndef RANDOM_VERTICAL_BAND_DISPLACEMENT_MACROS_SVH
`define RANDOM_VERTICAL_BAND_DISPLACEMENT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RVBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rvbd_pkg.sv]
// Package with the constants, register codes and types of the band displacement block.
package rvbd_pkg;

    // Sizing of the frame store and of the offset range.
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_PUSH   = 200;
    localparam int STORE_ROWS = 512;
    localparam int PERCENT    = 100;

    // Field and register widths.
    localparam int PIX_W      = 32;
    localparam int RND_W      = 16;
    localparam int BW_W       = 5;
    localparam int VAR_W      = 7;
    localparam int PUSH_W     = 8;
    localparam int IW_W       = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Derived widths.
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(STORE_ROWS);
    localparam int ADDR_W = $clog2(STORE_ROWS * MAX_WIDTH);
    localparam int P_W    = $clog2(MAX_PUSH + 1);
    localparam int PV_W   = $clog2(MAX_PUSH * PERCENT + 1);
    localparam int SPAN_W = $clog2(2 * MAX_PUSH + 2);
    localparam int SAT_W  = (SPAN_W > ROW_W) ? SPAN_W : ROW_W;

    // Reciprocal of one hundred for the floor division of push times variance.
    localparam int RECIP_SH = PV_W + 7;
    localparam int RECIP    = (1 << RECIP_SH) / PERCENT;
    localparam int RECIP_W  = RECIP_SH - 6;
    localparam int PROD_W   = PV_W + RECIP_W;

    // Result queue and credit counter.
    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    // Cycles the offset range needs to follow a register write.
    localparam int SETTLE_CYCLES = 4;
    localparam int SETTLE_W      = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANCE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUSH_DISTANCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd3;

    // Lowest offset and number of possible offsets of the draw.
    typedef struct packed {
        logic [P_W-1:0]    lo;
        logic [SPAN_W-1:0] span;
    } range_t;

    // One result item.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             displaced;
    } result_t;

    // Position of one item, captured when it is accepted.
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  rows_seen;
        logic [ROW_W-1:0]  write_row;
        logic              draw;
        logic [SPAN_W-1:0] scaled;
    } stage_t;

endpackage

[design/rvbd_range.sv]
// Pipeline that turns push distance and variance into the range of the random offset.
module rvbd_range
(
    input  logic                       clk,
    input  logic [rvbd_pkg::VAR_W-1:0] variance_percent,
    input  logic [rvbd_pkg::PUSH_W-1:0] push_distance,
    output rvbd_pkg::range_t           range
);
    import rvbd_pkg::*;

    logic [P_W-1:0]    p_sat;
    logic [VAR_W-1:0]  v_sat;
    logic [P_W-1:0]    p1_reg;
    logic [PV_W-1:0]   pv1_reg;
    logic [PROD_W-1:0] prod;
    logic [P_W-1:0]    p2_reg;
    logic [PV_W-1:0]   pv2_reg;
    logic [P_W-1:0]    qe2_reg;
    logic [PV_W-1:0]   rem;
    logic [P_W-1:0]    q_fix;
    logic              rem_left;
    logic [P_W-1:0]    p3_reg;
    logic [P_W-1:0]    floor3_reg;
    logic [P_W-1:0]    ceil3_reg;
    logic [P_W-1:0]    lo_reg;
    logic [SPAN_W-1:0] span_reg;

    always_comb
    begin
        p_sat = (int'(push_distance) > MAX_PUSH) ? P_W'(MAX_PUSH) : P_W'(push_distance);
        v_sat = (int'(variance_percent) > PERCENT) ? VAR_W'(PERCENT) : variance_percent;
    end

    // The reciprocal estimate is at most one below the true quotient.
    assign prod = PROD_W'(pv1_reg) * PROD_W'(RECIP);

    always_comb
    begin
        rem      = pv2_reg - PV_W'(qe2_reg * PERCENT);
        q_fix    = qe2_reg;
        if (int'(rem) >= PERCENT)
        begin
            rem   = rem - PV_W'(PERCENT);
            q_fix = qe2_reg + 1'b1;
        end
        rem_left = (rem != '0);
    end

    always_ff @(posedge clk)
    begin
        p1_reg     <= p_sat;
        pv1_reg    <= PV_W'(p_sat) * PV_W'(v_sat);
        p2_reg     <= p1_reg;
        pv2_reg    <= pv1_reg;
        qe2_reg    <= P_W'(prod >> RECIP_SH);
        p3_reg     <= p2_reg;
        floor3_reg <= q_fix;
        ceil3_reg  <= q_fix + P_W'(rem_left);
        lo_reg     <= p3_reg - ceil3_reg;
        span_reg   <= SPAN_W'(floor3_reg) + SPAN_W'(ceil3_reg) + SPAN_W'(1);
    end

    assign range.lo   = lo_reg;
    assign range.span = span_reg;

endmodule

[design/rvbd_store.sv]
// Frame store of original pixels with one write and one registered read per cycle.
module rvbd_store
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [rvbd_pkg::ADDR_W-1:0] wr_addr,
    input  logic [rvbd_pkg::PIX_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [rvbd_pkg::ADDR_W-1:0] rd_addr,
    output logic [rvbd_pkg::PIX_W-1:0]  rd_data
);
    import rvbd_pkg::*;

    logic [PIX_W-1:0] mem [STORE_ROWS*MAX_WIDTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/rvbd_fifo.sv]
// Small result queue that holds finished items until the output side takes them.
module rvbd_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rvbd_pkg::result_t din,
    input  logic              pop,
    output logic              not_empty,
    output rvbd_pkg::result_t dout
);
    import rvbd_pkg::*;

    result_t          entry_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == OUT_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == OUT_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    assign not_empty = (count_reg != '0);
    assign dout      = entry_reg[rd_ptr_reg];

endmodule

[design/random_vertical_band_displacement.sv]
// Top level of the random vertical band displacement block.
// The block takes pixels in raster order, top row first, and replaces each one by the
// original pixel a random number of rows above it in the same column. One offset is drawn
// per band of band_width columns in each row, from random_draw at the band's first pixel,
// uniformly between push minus and push plus push*variance/100. Pixels whose source row
// would lie above the top of the frame, or whose offset is zero, pass unchanged with
// displaced low. The block takes one item per clock while in_stall is low: every item
// costs one write of its pixel and at most one read of the frame store, and the two go
// to different rows in the same cycle, so nothing waits on the store. Results pass the
// store access and result select stages into the result queue. Up to four items may be
// in flight or waiting at the output; beyond that in_stall rises until the output side
// takes results. After reset and after every configuration write in_stall stays high
// while the offset range is recomputed. The user must see that configuration is written
// only while no item is in flight; the block does not enforce it. The frame store is
// not cleared; only rows already written in the current frame are ever read.
module random_vertical_band_displacement
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [rvbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rvbd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rvbd_pkg::PIX_W-1:0]      pixel_color,
    input  logic [rvbd_pkg::RND_W-1:0]      random_draw,
    input  logic                            start_of_frame,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rvbd_pkg::PIX_W-1:0]      shifted_pixel,
    output logic                            displaced
);
    import rvbd_pkg::*;

    // Configuration registers.
    logic [BW_W-1:0]   band_width_reg;
    logic [VAR_W-1:0]  variance_reg;
    logic [PUSH_W-1:0] push_reg;
    logic [IW_W-1:0]   image_width_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;

    // Raster position of the next item.
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] rows_reg;
    logic [ROW_W-1:0] rows_next;
    logic [ROW_W-1:0] wr_row_reg;
    logic [ROW_W-1:0] wr_row_next;
    logic [BW_W-1:0]  band_reg;
    logic [BW_W-1:0]  band_next;

    // Items accepted whose results have not been taken yet.
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    range_t range;
    logic   in_acc;
    logic   out_acc;

    // Position of the accepted item after start of frame and row wrap.
    logic [W_W-1:0]  w_eff;
    logic [BW_W-1:0] bw_eff;
    logic [COL_W-1:0] col_a;
    logic [ROW_W-1:0] rows_a;
    logic [ROW_W-1:0] wr_row_a;
    logic [BW_W-1:0]  band_a;
    logic             draw_a;
    logic [RND_W+SPAN_W-1:0] draw_prod;

    // Store access stage.
    stage_t           b_reg;
    logic             b_valid_reg;
    logic [ROW_W-1:0] cur_offset_reg;
    logic [SPAN_W-1:0] raw_offset;
    logic [ROW_W-1:0]  drawn_offset;
    logic [ROW_W-1:0]  offset_b;
    logic              disp_b;
    logic [ROW_W-1:0]  src_row;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    // Result select stage.
    logic             c_valid_reg;
    logic             c_disp_reg;
    logic [PIX_W-1:0] c_pix_reg;
    logic [PIX_W-1:0] store_data;
    result_t          c_result;
    result_t          out_result;

    assign in_stall = (int'(inflight_reg) >= OUT_DEPTH) || (settle_reg != '0);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;

    // Configuration writes restart the settle count so the range pipeline catches up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_width_reg  <= BW_W'(1);
            variance_reg    <= '0;
            push_reg        <= PUSH_W'(1);
            image_width_reg <= IW_W'(MAX_WIDTH);
            settle_reg      <= SETTLE_W'(SETTLE_CYCLES);
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_BAND_WIDTH:    band_width_reg  <= cfg_data[BW_W-1:0];
                    REG_VARIANCE:      variance_reg    <= cfg_data[VAR_W-1:0];
                    REG_PUSH_DISTANCE: push_reg        <= cfg_data[PUSH_W-1:0];
                    REG_IMAGE_WIDTH:   image_width_reg <= cfg_data[IW_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (cfg_write_en)
        begin
            settle_next = SETTLE_W'(SETTLE_CYCLES);
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    rvbd_range u_range
    (
        .clk              (clk),
        .variance_percent (variance_reg),
        .push_distance    (push_reg),
        .range            (range)
    );

    // Raster counters: position of the item being accepted and of the next one.
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_eff = W_W'(1);
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            w_eff = W_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = W_W'(image_width_reg);
        end
        bw_eff = (band_width_reg == '0) ? BW_W'(1) : band_width_reg;

        col_a    = col_reg;
        rows_a   = rows_reg;
        wr_row_a = wr_row_reg;
        band_a   = band_reg;
        if (start_of_frame)
        begin
            col_a    = '0;
            rows_a   = '0;
            wr_row_a = '0;
            band_a   = '0;
        end
        if (int'(col_a) >= int'(w_eff))
        begin
            col_a  = '0;
            band_a = '0;
        end
        draw_a = (col_a == '0) || (band_a == '0);

        band_next   = (int'(band_a) + 1 >= int'(bw_eff)) ? '0 : band_a + 1'b1;
        col_next    = col_a + 1'b1;
        rows_next   = rows_a;
        wr_row_next = wr_row_a;
        if (int'(col_a) + 1 >= int'(w_eff))
        begin
            col_next    = '0;
            band_next   = '0;
            wr_row_next = (int'(wr_row_a) == STORE_ROWS - 1) ? '0 : wr_row_a + 1'b1;
            if (int'(rows_a) < STORE_ROWS - 1)
            begin
                rows_next = rows_a + 1'b1;
            end
        end
    end

    // Multiply-high scaling of the random word onto the span of offsets.
    assign draw_prod = (RND_W+SPAN_W)'(random_draw) * (RND_W+SPAN_W)'(range.span);

    always_comb
    begin
        inflight_next = inflight_reg + CNT_W'(in_acc) - CNT_W'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            rows_reg     <= '0;
            wr_row_reg   <= '0;
            band_reg     <= '0;
            inflight_reg <= '0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            b_valid_reg  <= in_acc;
            if (in_acc)
            begin
                col_reg    <= col_next;
                rows_reg   <= rows_next;
                wr_row_reg <= wr_row_next;
                band_reg   <= band_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            b_reg.pixel     <= pixel_color;
            b_reg.col       <= col_a;
            b_reg.rows_seen <= rows_a;
            b_reg.write_row <= wr_row_a;
            b_reg.draw      <= draw_a;
            b_reg.scaled    <= SPAN_W'(draw_prod >> RND_W);
        end
    end

    // Store access stage: finish the offset, decide on displacement and address the store.
    // Whenever the store is read, the source row differs from the row being written, so
    // the read and the write of one cycle never meet in the same entry.
    always_comb
    begin
        raw_offset = SPAN_W'(range.lo) + b_reg.scaled;
        if (SAT_W'(raw_offset) > SAT_W'(STORE_ROWS - 1))
        begin
            drawn_offset = ROW_W'(STORE_ROWS - 1);
        end
        else
        begin
            drawn_offset = ROW_W'(raw_offset);
        end
        offset_b = b_reg.draw ? drawn_offset : cur_offset_reg;
        disp_b   = (offset_b != '0) && (offset_b <= b_reg.rows_seen);
        if (b_reg.write_row >= offset_b)
        begin
            src_row = b_reg.write_row - offset_b;
        end
        else
        begin
            src_row = ROW_W'(int'(b_reg.write_row) + STORE_ROWS - int'(offset_b));
        end
        rd_addr = ADDR_W'(ADDR_W'(src_row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(b_reg.col);
        wr_addr = ADDR_W'(ADDR_W'(b_reg.write_row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(b_reg.col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_offset_reg <= '0;
            c_valid_reg    <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
            if (b_valid_reg && b_reg.draw)
            begin
                cur_offset_reg <= drawn_offset;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_disp_reg <= disp_b;
        c_pix_reg  <= b_reg.pixel;
    end

    rvbd_store u_store
    (
        .clk     (clk),
        .wr_en   (b_valid_reg),
        .wr_addr (wr_addr),
        .wr_data (b_reg.pixel),
        .rd_en   (b_valid_reg && disp_b),
        .rd_addr (rd_addr),
        .rd_data (store_data)
    );

    // Result select: the stored original when displaced, else the item's own pixel.
    assign c_result.pixel     = c_disp_reg ? store_data : c_pix_reg;
    assign c_result.displaced = c_disp_reg;

    rvbd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (c_valid_reg),
        .din       (c_result),
        .pop       (out_acc),
        .not_empty (out_valid),
        .dout      (out_result)
    );

    assign shifted_pixel = out_result.pixel;
    assign displaced     = out_result.displaced;

endmodule

[design/rvbd_checker.sv]
// Port checker of the band displacement block and its bind to the top level.
`include "random_vertical_band_displacement_macros.svh"

module rvbd_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cfg_write_en,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [rvbd_pkg::PIX_W-1:0] shifted_pixel,
    input logic                       displaced
);
    import rvbd_pkg::*;

    // Items accepted at the input and not yet taken at the output.
    logic [CNT_W:0] pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + (CNT_W+1)'(in_valid && !in_stall)
                           - (CNT_W+1)'(out_valid && !out_stall);
        end
    end

    `RVBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
    `RVBD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(shifted_pixel) && $stable(displaced), "stalled result changed")
    `RVBD_ASSERT_NEXT(a_cfg_settle, cfg_write_en, in_stall, "item taken while range settles")
    `RVBD_ASSERT_NOW(a_no_extra, out_valid, pending_reg != '0, "result without an item")
    `RVBD_ASSERT_NOW(a_credit, int'(pending_reg) >= OUT_DEPTH, in_stall, "too many items in flight")

endmodule

bind random_vertical_band_displacement rvbd_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .shifted_pixel (shifted_pixel),
    .displaced     (displaced)
);

[tb/random_vertical_band_displacement_tb.sv]
// Self-checking testbench for the random vertical band displacement block.
`timescale 1ns / 1ps

module random_vertical_band_displacement_tb;

    import rvbd_pkg::*;

    // The run is ended by force if it goes on this long. The slowest correct run takes
    // under a thousand items, so this is many times over.
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Random frames are issued until this many items have gone in; the deep frame at
    // the end brings the total to at least 700.
    localparam int unsigned RANDOM_UNTIL = 490;

    // Only the first mismatches are printed, so a broken block cannot flood the log.
    localparam int unsigned PRINT_LIMIT = 20;

    // Scoreboard: it keeps its own copy of the registers, the frame position and the
    // stored rows, predicts the result of every accepted item and holds the predicted
    // results in order until the block delivers them.
    class band_shift_scoreboard;

        logic [BW_W-1:0]   cfg_band_width = 1;
        logic [VAR_W-1:0]  cfg_spread_pct = 0;
        logic [PUSH_W-1:0] cfg_push       = 1;
        logic [IW_W-1:0]   cfg_width      = 512;

        int unsigned col_pos       = 0;
        int unsigned rows_in_frame = 0;
        int unsigned band_pos      = 0;
        int unsigned band_offset   = 0;
        int unsigned store_row     = 0;

        // Copy of every pixel written, row by row, at the full row pitch.
        bit [PIX_W-1:0] frame_copy [STORE_ROWS * MAX_WIDTH];

        result_t     expected_pixels [$];
        int unsigned mismatches = 0;

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BAND_WIDTH:    cfg_band_width = data[BW_W-1:0];
                REG_VARIANCE:      cfg_spread_pct = data[VAR_W-1:0];
                REG_PUSH_DISTANCE: cfg_push       = data[PUSH_W-1:0];
                REG_IMAGE_WIDTH:   cfg_width      = data[IW_W-1:0];
                default: ;
            endcase
        endfunction

        // Maps the random word onto the inclusive range push - ceil(push*spread/100)
        // up to push + floor(push*spread/100) by taking the high half of the product.
        function int unsigned pick_offset(logic [RND_W-1:0] rnd);
            int unsigned push_sat;
            int unsigned spread_sat;
            int unsigned product;
            int unsigned lowest;
            int unsigned highest;
            int unsigned picked;
            push_sat   = (cfg_push > MAX_PUSH) ? MAX_PUSH : cfg_push;
            spread_sat = (cfg_spread_pct > PERCENT) ? PERCENT : cfg_spread_pct;
            product    = push_sat * spread_sat;
            lowest     = push_sat - (product + PERCENT - 1) / PERCENT;
            highest    = push_sat + product / PERCENT;
            picked     = lowest + ((int'(rnd) * (highest - lowest + 1)) >> RND_W);
            if (picked > STORE_ROWS - 1)
                picked = STORE_ROWS - 1;
            return picked;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix, logic [RND_W-1:0] rnd, logic sof);
            int unsigned row_len;
            int unsigned band_len;
            int unsigned src_row;
            result_t     res;
            row_len  = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
            band_len = (cfg_band_width == 0) ? 1 : cfg_band_width;
            res.pixel     = pix;
            res.displaced = 1'b0;

            if (sof)
            begin
                col_pos       = 0;
                rows_in_frame = 0;
                band_pos      = 0;
                store_row     = 0;
            end
            if (col_pos >= row_len)
            begin
                col_pos  = 0;
                band_pos = 0;
            end
            if (col_pos == 0 || band_pos == 0)
            begin
                band_pos    = 0;
                band_offset = pick_offset(rnd);
            end

            // The source row must already belong to this frame.
            if (band_offset != 0 && band_offset <= rows_in_frame)
            begin
                src_row       = (store_row + STORE_ROWS - band_offset) % STORE_ROWS;
                res.pixel     = frame_copy[src_row * MAX_WIDTH + col_pos];
                res.displaced = 1'b1;
            end
            frame_copy[store_row * MAX_WIDTH + col_pos] = pix;

            band_pos++;
            if (band_pos >= band_len)
                band_pos = 0;
            col_pos++;
            if (col_pos >= row_len)
            begin
                col_pos   = 0;
                band_pos  = 0;
                store_row = (store_row + 1) % STORE_ROWS;
                if (rows_in_frame < STORE_ROWS - 1)
                    rows_in_frame++;
            end
            expected_pixels.insert(expected_pixels.size(), res);
        endfunction

        function void check_pixel(logic [PIX_W-1:0] pix, logic disp);
            result_t want;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: result with nothing pending: expected none, actual %h/%b",
                             $time, pix, disp);
                return;
            end
            want = expected_pixels.pop_front();
            if (pix !== want.pixel)
            begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: shifted_pixel mismatch: expected %h, actual %h",
                             $time, want.pixel, pix);
            end
            if (disp !== want.displaced)
            begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: displaced mismatch: expected %b, actual %b",
                             $time, want.displaced, disp);
            end
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

    endclass

    // Every input of the block starts at a known value.
    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_write_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel_color    = '0;
    logic [RND_W-1:0]      random_draw    = '0;
    logic                  start_of_frame = 1'b0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [PIX_W-1:0]      shifted_pixel;
    logic                  displaced;

    band_shift_scoreboard sb = new;

    // Chance in percent, per item or per cycle, that a burst of idling starts.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned pixels_sent  = 0;
    int unsigned cycle_count  = 0;

    random_vertical_band_displacement dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel_color    (pixel_color),
        .random_draw    (random_draw),
        .start_of_frame (start_of_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .shifted_pixel  (shifted_pixel),
        .displaced      (displaced)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // All inputs change only at rising edges, so the handshake signals seen at the
    // falling edge are exactly the values that the next rising edge will act on. The
    // result is checked here, at the falling edge before the rising edge that takes it.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pixel(shifted_pixel, displaced);
    end

    // Output side: stalls come in random bursts, never lowered and raised again in the
    // same step.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Offers one item and returns at the rising edge that accepts it. The item is handed
    // to the scoreboard at the falling edge before that edge, when acceptance is certain.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [RND_W-1:0] rnd,
                              input logic sof);
        bit took;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        pixel_color    <= pix;
        random_draw    <= rnd;
        start_of_frame <= sof;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            if (took)
                sb.note_pixel(pix, rnd, sof);
            @(posedge clk);
        end
        while (!took);
        pixels_sent++;
    endtask

    // Holds the input side idle until every predicted result has been checked. It always
    // waits for a rising edge before returning, so in_valid is never driven twice in one step.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // One register write per edge; the caller lowers the write enable afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        sb.set_register(idx, data);
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] band_cols,
                             input logic [CFG_DATA_W-1:0] spread_pct,
                             input logic [CFG_DATA_W-1:0] push,
                             input logic [CFG_DATA_W-1:0] row_len);
        write_reg(REG_BAND_WIDTH, band_cols);
        write_reg(REG_VARIANCE, spread_pct);
        write_reg(REG_PUSH_DISTANCE, push);
        write_reg(REG_IMAGE_WIDTH, row_len);
        cfg_write_en <= 1'b0;
    endtask

    // One frame of random pixels. The first item always starts the frame; a noisy frame
    // also restarts at random points, which leaves rows unfinished. Random words lean
    // toward the two ends of their range now and then; some frames also pause once to drain.
    task automatic run_frame(input int unsigned n_pixels, input bit noisy, input bit may_pause);
        int unsigned   pause_at;
        logic          sof;
        logic [RND_W-1:0] rnd;
        pause_at = (may_pause && $urandom_range(0, 3) == 0) ?
                   $urandom_range(1, n_pixels - 1) : n_pixels;
        for (int unsigned i = 0; i < n_pixels; i++)
        begin
            if (i == pause_at)
                wait_drained();
            sof = (i == 0) || (noisy && $urandom_range(0, 49) == 0);
            case ($urandom_range(0, 7))
                0:       rnd = '0;
                1:       rnd = '1;
                default: rnd = RND_W'($urandom);
            endcase
            send_pixel($urandom, rnd, sof);
        end
    endtask

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    initial
    begin
        int unsigned cols;
        int unsigned push;
        int unsigned spread;
        int unsigned rows;
        int unsigned n_pixels;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. First a band width of zero, which counts as one column, with a
        // two-pixel row and no start of frame at all: the frame position simply runs on
        // from reset, so every pixel from the second row on comes from one row above.
        configure(10'd0, 10'd0, 10'd1, 10'd2);
        send_pixel('0, '0, 1'b0);
        send_pixel('1, '1, 1'b0);
        send_pixel(32'h00FF_00FF, 16'h8000, 1'b0);
        send_pixel(32'hFF00_FF00, 16'h7FFF, 1'b0);
        send_pixel('1, '0, 1'b0);
        send_pixel('0, '1, 1'b0);
        wait_drained();

        // Five-pixel rows in bands of three, so the second band of each row is cut short.
        // Push 1 with full spread gives offsets 0 to 2: a word of zero draws offset zero,
        // which keeps the pixel, and the top word draws two rows up, which only lands once
        // two rows exist. Halfway through, the input side waits for every result.
        configure(10'd3, 10'd100, 10'd1, 10'd5);
        for (int unsigned i = 0; i < 15; i++)
        begin
            if (i == 7)
                wait_drained();
            send_pixel($urandom, (i % 2) ? 16'hFFFF : 16'h0000, i == 0);
        end
        wait_drained();

        // Out-of-range values: width zero acts as one, push 255 is cut to the largest
        // push and a spread of 127 percent to 100 percent.
        configure(10'd31, 10'd127, 10'd255, 10'd0);
        send_pixel($urandom, '0, 1'b1);
        send_pixel($urandom, '1, 1'b0);
        send_pixel($urandom, 16'h1234, 1'b0);
        wait_drained();

        // A width beyond the row buffer is cut to the full row length.
        write_reg(REG_IMAGE_WIDTH, 10'd1023);
        cfg_write_en <= 1'b0;
        send_pixel($urandom, RND_W'($urandom), 1'b1);
        send_pixel($urandom, RND_W'($urandom), 1'b0);

        // Random part. Most frames are small and last a few rows longer than the largest
        // offset they can draw, so displaced pixels are frequent. Now and then every
        // register gets raw random bits instead, which exercises the masking and limits.
        while (pixels_sent < RANDOM_UNTIL)
        begin
            wait_drained();
            tx_idle_pct = pick_idle_pct();
            rx_idle_pct = pick_idle_pct();
            if ($urandom_range(0, 7) == 0)
            begin
                configure(CFG_DATA_W'($urandom_range(0, 1023)),
                          CFG_DATA_W'($urandom_range(0, 1023)),
                          CFG_DATA_W'($urandom_range(0, 1023)),
                          CFG_DATA_W'($urandom_range(0, 1023)));
                run_frame($urandom_range(20, 40), 1'b1, 1'b1);
            end
            else
            begin
                cols = $urandom_range(1, 6);
                push = $urandom_range(1, 8);
                case ($urandom_range(0, 3))
                    0:       spread = 0;
                    1:       spread = 100;
                    default: spread = $urandom_range(0, 100);
                endcase
                rows     = push + (push * spread) / 100 + $urandom_range(1, 3);
                n_pixels = cols * rows;
                if (n_pixels > 120)
                    n_pixels = 120;
                if (n_pixels < 2)
                    n_pixels = 2;
                configure(CFG_DATA_W'($urandom_range(1, 20)), CFG_DATA_W'(spread),
                          CFG_DATA_W'(push), CFG_DATA_W'(cols));
                run_frame(n_pixels, $urandom_range(0, 3) == 0, 1'b1);
            end
        end

        // Last part, with no idling on either side: a one-column frame at the largest
        // push and a band width of 20, long enough that the deepest rows finally reach back
        // to the top of the frame.
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(10'd20, 10'd0, 10'd200, 10'd1);
        run_frame(210, 1'b0, 1'b0);

        // Let the pipeline empty, then keep the clock running so that any stray result can still show up.
        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[random_vertical_band_displacement.f]
+incdir+design
design/rvbd_pkg.sv
design/rvbd_range.sv
design/rvbd_store.sv
design/rvbd_fifo.sv
design/random_vertical_band_displacement.sv
design/rvbd_checker.sv
tb/random_vertical_band_displacement_tb.sv
